FILE: sv/ugbp_pkg.sv
// Shared types and constants for the uniform grid broad-phase unit.
// No dependencies.
package ugbp_pkg;

  localparam int MAX_ENTITIES = 64;
  localparam int GRID_DIM     = 32;
  localparam int GRID_BITS    = $clog2(GRID_DIM);
  localparam int NUM_CELLS    = GRID_DIM * GRID_DIM;
  localparam int CELL_AW      = $clog2(NUM_CELLS);
  localparam int ID_W         = 6;
  localparam int POS_W        = 24;
  localparam int EXT_W        = 22;
  localparam int CFG_W        = 23;
  localparam int MASK_W       = 64;
  localparam int RECT_W       = 4 * GRID_BITS;
  localparam int DELTA_W      = 26;
  localparam int REM_W        = DELTA_W - 1;
  localparam int SHW          = CFG_W + GRID_BITS + 1;
  localparam int KW           = $clog2(GRID_BITS + 1);

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] CFG_HALF_X    = 2'd0;
  localparam logic [1:0] CFG_HALF_Y    = 2'd1;
  localparam logic [1:0] CFG_CELL_SIZE = 2'd2;

  typedef enum logic [1:0] {
    CMD_UPDATE,
    CMD_REMOVE,
    CMD_QUERY,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic [GRID_BITS-1:0] x0;
    logic [GRID_BITS-1:0] y0;
    logic [GRID_BITS-1:0] x1;
    logic [GRID_BITS-1:0] y1;
  } rect_t;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [ID_W-1:0] id;
    rect_t           rect;
    logic            clamped;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOAD,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_LOAD,
    B_RD,
    B_WR,
    B_DONE
  } back_state_e;

  typedef enum logic [1:0] {
    W_CLR,
    W_SET,
    W_OR
  } walk_mode_e;

endpackage

FILE: sv/ugbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ugbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ugbp_front.sv
// Front end: accepts items, computes clamped cell rectangles with a shared
// restoring divider, and pushes commands to the queue. Uses ugbp_pkg.
module ugbp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [ugbp_pkg::ID_W-1:0]  entity_id_i,
  input  logic [ugbp_pkg::POS_W-1:0] pos_x_i,
  input  logic [ugbp_pkg::POS_W-1:0] pos_y_i,
  input  logic [ugbp_pkg::EXT_W-1:0] half_w_i,
  input  logic [ugbp_pkg::EXT_W-1:0] half_h_i,
  input  logic [ugbp_pkg::CFG_W-1:0] grid_half_x_i,
  input  logic [ugbp_pkg::CFG_W-1:0] grid_half_y_i,
  input  logic [ugbp_pkg::CFG_W-1:0] cell_size_i,
  output logic                       push_o,
  output ugbp_pkg::cmd_t             cmd_o,
  input  logic                       full_i
);
  import ugbp_pkg::*;

  front_state_e         state_q, state_d;
  cmd_kind_e            kind_q, kind_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic [POS_W-1:0]     px_q, px_d, py_q, py_d;
  logic [EXT_W-1:0]     ew_q, ew_d, eh_q, eh_d;
  logic [1:0]           j_q, j_d;
  logic [KW-1:0]        k_q, k_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 neg_q, neg_d;
  logic [GRID_BITS-1:0] qt_q, qt_d;
  logic [GRID_BITS-1:0] idx_q [4];
  logic [GRID_BITS-1:0] idx_d [4];
  logic                 clamp_q, clamp_d;

  logic [CFG_W-1:0]     cs;
  logic [SHW-1:0]       dvs;
  logic                 trial;
  logic [DELTA_W-1:0]   delta;
  logic                 accept;
  logic                 fin;
  logic [GRID_BITS-1:0] fin_idx;

  assign accept = in_valid_i && in_ready_o;
  assign cs     = (cell_size_i == '0) ? CFG_W'(1) : cell_size_i;
  assign dvs    = SHW'(cs) << k_q;
  assign trial  = SHW'(rem_q) >= dvs;

  always_comb begin
    logic [DELTA_W-1:0] base;
    logic [DELTA_W-1:0] half;
    logic [DELTA_W-1:0] ext;
    base  = j_q[0] ? DELTA_W'($signed(py_q)) : DELTA_W'($signed(px_q));
    half  = j_q[0] ? DELTA_W'(grid_half_y_i) : DELTA_W'(grid_half_x_i);
    ext   = j_q[0] ? {(DELTA_W-1)'(eh_q), 1'b0} : {(DELTA_W-1)'(ew_q), 1'b0};
    delta = base + half + (j_q[1] ? ext : '0);
  end

  always_comb begin
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (opcode_i == OP_UPDATE || opcode_i == OP_QUERY) ? F_LOAD : F_PUSH;
        end else begin
          state_d = F_IDLE;
        end
      end
      F_LOAD:  state_d = F_DIV;
      F_DIV:   state_d = (fin && j_q == 2'd3) ? F_PUSH : (fin ? F_LOAD : F_DIV);
      F_PUSH:  state_d = full_i ? F_PUSH : F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    fin     = 1'b0;
    fin_idx = qt_q;
    kind_d  = kind_q;
    id_d    = id_q;
    px_d    = px_q;
    py_d    = py_q;
    ew_d    = ew_q;
    eh_d    = eh_q;
    j_d     = j_q;
    k_d     = k_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    qt_d    = qt_q;
    idx_d   = idx_q;
    clamp_d = clamp_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_UPDATE: kind_d = CMD_UPDATE;
            OP_REMOVE: kind_d = CMD_REMOVE;
            OP_QUERY:  kind_d = CMD_QUERY;
            default:   kind_d = CMD_NOP;
          endcase
          id_d    = entity_id_i;
          px_d    = pos_x_i;
          py_d    = pos_y_i;
          ew_d    = half_w_i;
          eh_d    = half_h_i;
          j_d     = 2'd0;
          clamp_d = 1'b0;
        end
      end
      F_LOAD: begin
        rem_d = delta[REM_W-1:0];
        neg_d = delta[DELTA_W-1];
        k_d   = KW'(GRID_BITS);
        qt_d  = '0;
      end
      F_DIV: begin
        if (k_q == KW'(GRID_BITS)) begin
          if (neg_q || trial) begin
            fin     = 1'b1;
            fin_idx = neg_q ? '0 : GRID_BITS'(GRID_DIM - 1);
            clamp_d = 1'b1;
          end else begin
            k_d = k_q - 1'b1;
          end
        end else begin
          if (trial) begin
            rem_d = rem_q - REM_W'(dvs);
          end
          fin_idx = qt_q | (trial ? (GRID_BITS'(1) << k_q) : '0);
          qt_d    = fin_idx;
          if (k_q == '0) begin
            fin = 1'b1;
          end else begin
            k_d = k_q - 1'b1;
          end
        end
        if (fin) begin
          idx_d[j_q] = fin_idx;
          j_d        = j_q + 1'b1;
        end
      end
      F_PUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    id_q    <= id_d;
    px_q    <= px_d;
    py_q    <= py_d;
    ew_q    <= ew_d;
    eh_q    <= eh_d;
    j_q     <= j_d;
    k_q     <= k_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    qt_q    <= qt_d;
    idx_q   <= idx_d;
    clamp_q <= clamp_d;
  end

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_o       = (state_q == F_PUSH) && !full_i;
  assign cmd_o.kind   = kind_q;
  assign cmd_o.id     = id_q;
  assign cmd_o.rect   = '{x0: idx_q[0], y0: idx_q[1], x1: idx_q[2], y1: idx_q[3]};
  assign cmd_o.clamped = clamp_q && (kind_q == CMD_UPDATE || kind_q == CMD_QUERY);

endmodule

FILE: sv/ugbp_fifo.sv
// Two-entry command queue between front and back end.
// Uses ugbp_pkg.
module ugbp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ugbp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ugbp_pkg::cmd_t data_o
);
  import ugbp_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? !wp_q : wp_q;
    rp_d  = pop_i ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

endmodule

FILE: sv/ugbp_back.sv
// Back end: clears the cell memory after reset, then walks cell rectangles
// to clear, mark or gather bitmaps. Uses ugbp_pkg and ugbp_ram.
module ugbp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  ugbp_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ugbp_pkg::MASK_W-1:0] found_mask_o,
  output logic                        clamped_o
);
  import ugbp_pkg::*;

  back_state_e              state_q, state_d;
  cmd_t                     cmd_q, cmd_d;
  walk_mode_e               mode_q, mode_d;
  logic [GRID_BITS-1:0]     cx_q, cx_d, cy_q, cy_d, wx0_q, wx0_d, wx1_q, wx1_d, wy1_q, wy1_d;
  logic [MASK_W-1:0]        acc_q, acc_d;
  logic [CELL_AW:0]         clr_q, clr_d;
  logic [MAX_ENTITIES-1:0]  valid_q, valid_d;
  logic                     ov_q, ov_d;
  logic [MASK_W-1:0]        omask_q, omask_d;
  logic                     oclamp_q, oclamp_d;

  logic                     cell_we;
  logic [CELL_AW-1:0]       cell_waddr, cell_addr;
  logic [MASK_W-1:0]        cell_wdata, cell_rdata;
  logic                     rect_we;
  rect_t                    rect_rdata;
  logic [MASK_W-1:0]        bit_m;
  logic                     last;
  logic                     out_free;
  logic                     has_old;

  assign cell_addr = CELL_AW'(cy_q) * CELL_AW'(GRID_DIM) + CELL_AW'(cx_q);
  assign bit_m     = MASK_W'(1) << cmd_q.id;
  assign last      = (cx_q == wx1_q) && (cy_q == wy1_q);
  assign out_free  = !ov_q || out_ready_i;
  assign has_old   = (cmd_q.kind == CMD_UPDATE || cmd_q.kind == CMD_REMOVE)
                     && valid_q[cmd_q.id];

  ugbp_ram #(.WIDTH(MASK_W), .DEPTH(NUM_CELLS)) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_addr),
    .rdata_o (cell_rdata)
  );

  ugbp_ram #(.WIDTH(RECT_W), .DEPTH(MAX_ENTITIES)) u_rects (
    .clk_i   (clk_i),
    .we_i    (rect_we),
    .waddr_i (cmd_q.id),
    .wdata_i (cmd_q.rect),
    .raddr_i (cmd_i.id),
    .rdata_o (rect_rdata)
  );

  always_comb begin
    unique case (state_q)
      B_CLEAR: state_d = (clr_q == (CELL_AW + 1)'(NUM_CELLS - 1)) ? B_IDLE : B_CLEAR;
      B_IDLE:  state_d = cmd_valid_i ? B_LOAD : B_IDLE;
      B_LOAD: begin
        if (has_old || cmd_q.kind == CMD_UPDATE || cmd_q.kind == CMD_QUERY) begin
          state_d = B_RD;
        end else begin
          state_d = B_DONE;
        end
      end
      B_RD:    state_d = B_WR;
      B_WR: begin
        if (!last) begin
          state_d = B_RD;
        end else if (mode_q == W_CLR && cmd_q.kind == CMD_UPDATE) begin
          state_d = B_RD;
        end else begin
          state_d = B_DONE;
        end
      end
      B_DONE:  state_d = out_free ? B_IDLE : B_DONE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_d      = cmd_q;
    mode_d     = mode_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    wx0_d      = wx0_q;
    wx1_d      = wx1_q;
    wy1_d      = wy1_q;
    acc_d      = acc_q;
    clr_d      = clr_q;
    valid_d    = valid_q;
    ov_d       = ov_q && !out_ready_i;
    omask_d    = omask_q;
    oclamp_d   = oclamp_q;
    pop_o      = 1'b0;
    cell_we    = 1'b0;
    cell_waddr = cell_addr;
    cell_wdata = cell_rdata;
    rect_we    = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q[CELL_AW-1:0];
        cell_wdata = '0;
        clr_d      = clr_q + 1'b1;
      end
      B_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
        end
      end
      B_LOAD: begin
        acc_d = '0;
        if (has_old) begin
          mode_d = W_CLR;
          cx_d   = rect_rdata.x0;
          cy_d   = rect_rdata.y0;
          wx0_d  = rect_rdata.x0;
          wx1_d  = rect_rdata.x1;
          wy1_d  = rect_rdata.y1;
        end else begin
          mode_d = (cmd_q.kind == CMD_QUERY) ? W_OR : W_SET;
          cx_d   = cmd_q.rect.x0;
          cy_d   = cmd_q.rect.y0;
          wx0_d  = cmd_q.rect.x0;
          wx1_d  = cmd_q.rect.x1;
          wy1_d  = cmd_q.rect.y1;
        end
      end
      B_RD: ;
      B_WR: begin
        unique case (mode_q)
          W_CLR: begin
            cell_we    = 1'b1;
            cell_wdata = cell_rdata & ~bit_m;
          end
          W_SET: begin
            cell_we    = 1'b1;
            cell_wdata = cell_rdata | bit_m;
          end
          default: acc_d = acc_q | cell_rdata;
        endcase
        if (cx_q == wx1_q) begin
          cx_d = wx0_q;
          cy_d = cy_q + 1'b1;
        end else begin
          cx_d = cx_q + 1'b1;
        end
        if (last) begin
          if (mode_q == W_CLR) begin
            valid_d[cmd_q.id] = 1'b0;
            if (cmd_q.kind == CMD_UPDATE) begin
              mode_d = W_SET;
              cx_d   = cmd_q.rect.x0;
              cy_d   = cmd_q.rect.y0;
              wx0_d  = cmd_q.rect.x0;
              wx1_d  = cmd_q.rect.x1;
              wy1_d  = cmd_q.rect.y1;
            end
          end else if (mode_q == W_SET) begin
            valid_d[cmd_q.id] = 1'b1;
            rect_we           = 1'b1;
          end
        end
      end
      B_DONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          omask_d  = (cmd_q.kind == CMD_QUERY) ? acc_q : '0;
          oclamp_d = cmd_q.clamped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      valid_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    mode_q   <= mode_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    wx0_q    <= wx0_d;
    wx1_q    <= wx1_d;
    wy1_q    <= wy1_d;
    acc_q    <= acc_d;
    omask_q  <= omask_d;
    oclamp_q <= oclamp_d;
  end

  assign out_valid_o  = ov_q;
  assign found_mask_o = omask_q;
  assign clamped_o    = oclamp_q;

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CLEAR |-> !pop_o)
    else $error("queue popped during memory clear");
  a_cursor_in_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_RD |-> (cx_q <= wx1_q && cy_q <= wy1_q))
    else $error("walk cursor left its rectangle");
  a_set_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WR && mode_q == W_SET) |-> cmd_q.kind == CMD_UPDATE)
    else $error("cell marked by a non-update item");
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE && out_free) |=> ov_q)
    else $error("finished item produced no result");
`endif

endmodule

FILE: sv/uniform_grid_broad_phase_unit.sv
// Top level of the uniform grid broad-phase unit: config registers, front
// end, command queue and back end. Uses ugbp_pkg, ugbp_front/fifo/back.
//
//  channel  | direction | tdata                                  | tuser
//  s_axis   | in        | entity_id, pos_x, pos_y, half_w, half_h | opcode
//  m_axis   | out       | found_mask                             | clamped
//  cfg      | in        | cfg_we_i / cfg_idx_i / cfg_data_i, no read-back
//
// Front: update and query pass all four bounds through the shared divider (a load
// step, an overflow check, then one quotient bit per cycle); remove skips it.
// Back: each cell visited is a registered cell memory read then write, old
// plus new rectangle on update. After reset the back end clears the
// 1024-entry cell memory; items queue meanwhile. Either side may stall
// through the two-entry queue.
module uniform_grid_broad_phase_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [103:0]               s_axis_tdata,  // entity_id, pos_x, pos_y, half_w, half_h
  input  logic [1:0]                 s_axis_tuser,  // opcode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,  // found_mask
  output logic                       m_axis_tuser,  // clamped
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ugbp_pkg::CFG_W-1:0] cfg_data_i
);
  import ugbp_pkg::*;

  logic [CFG_W-1:0] half_x_q, half_y_q, cell_size_q;
  logic             push, full, pop, cmd_valid;
  cmd_t             cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_x_q    <= CFG_W'(2048);
      half_y_q    <= CFG_W'(2048);
      cell_size_q <= CFG_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_X:    half_x_q    <= cfg_data_i;
        CFG_HALF_Y:    half_y_q    <= cfg_data_i;
        CFG_CELL_SIZE: cell_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ugbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .entity_id_i   (s_axis_tdata[5:0]),
    .pos_x_i       (s_axis_tdata[29:6]),
    .pos_y_i       (s_axis_tdata[53:30]),
    .half_w_i      (s_axis_tdata[75:54]),
    .half_h_i      (s_axis_tdata[97:76]),
    .grid_half_x_i (half_x_q),
    .grid_half_y_i (half_y_q),
    .cell_size_i   (cell_size_q),
    .push_o        (push),
    .cmd_o         (cmd_in),
    .full_i        (full)
  );

  ugbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  ugbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .found_mask_o (m_axis_tdata),
    .clamped_o    (m_axis_tuser)
  );

endmodule

FILE: bench/tb.sv
// Self-checking bench for uniform_grid_broad_phase_unit: directed table then random
// update/remove/query items, checked against a behavioral grid predictor.
// Depends on ugbp_pkg and the unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ugbp_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  id;
    logic [23:0] px;
    logic [23:0] py;
    logic [21:0] hw;
    logic [21:0] hh;
    logic        has_exp;
    logic [63:0] exp_mask;
    logic        exp_clamp;
  } stim_t;

  typedef struct {
    logic [63:0] mask;
    logic        clamp;
  } grid_result_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  uniform_grid_broad_phase_unit u_top (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  logic [63:0] cells [NUM_CELLS];
  logic        ent_valid [MAX_ENTITIES];
  int          ent_x0 [MAX_ENTITIES], ent_y0 [MAX_ENTITIES];
  int          ent_x1 [MAX_ENTITIES], ent_y1 [MAX_ENTITIES];
  logic [CFG_W-1:0] half_x, half_y, csize;
  grid_result_t pending [$];
  int errors = 0;
  int cycles = 0;
  bit in_calm = 0, out_calm = 0;

  function automatic int to_cell(longint d, ref logic clamp);
    longint cs, q;
    cs = (csize == 0) ? 1 : csize;
    if (d < 0) begin
      clamp = 1;
      return 0;
    end
    q = d / cs;
    if (q >= GRID_DIM) begin
      clamp = 1;
      return GRID_DIM - 1;
    end
    return int'(q);
  endfunction

  function automatic void evict(int id);
    if (!ent_valid[id]) return;
    for (int y = ent_y0[id]; y <= ent_y1[id]; y++)
      for (int x = ent_x0[id]; x <= ent_x1[id]; x++)
        cells[y*GRID_DIM+x][id] = 1'b0;
    ent_valid[id] = 0;
    ent_x0[id] = 0; ent_y0[id] = 0; ent_x1[id] = 0; ent_y1[id] = 0;
  endfunction

  function automatic grid_result_t apply_grid_op(stim_t s);
    grid_result_t r;
    longint px, py;
    int x0, y0, x1, y1;
    logic cl;
    r.mask = '0;
    cl = 0;
    px = longint'($signed(s.px));
    py = longint'($signed(s.py));
    if (s.op == OP_UPDATE || s.op == OP_QUERY) begin
      x0 = to_cell(px + half_x, cl);
      y0 = to_cell(py + half_y, cl);
      x1 = to_cell(px + 2*longint'(s.hw) + half_x, cl);
      y1 = to_cell(py + 2*longint'(s.hh) + half_y, cl);
    end
    if (s.op == OP_UPDATE) begin
      evict(s.id);
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++)
          cells[y*GRID_DIM+x][s.id] = 1'b1;
      ent_valid[s.id] = 1;
      ent_x0[s.id] = x0; ent_y0[s.id] = y0; ent_x1[s.id] = x1; ent_y1[s.id] = y1;
    end else if (s.op == OP_REMOVE) begin
      evict(s.id);
    end else if (s.op == OP_QUERY) begin
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++)
          r.mask |= cells[y*GRID_DIM+x];
    end
    r.clamp = (s.op == OP_UPDATE || s.op == OP_QUERY) ? cl : 1'b0;
    return r;
  endfunction

  task automatic send_item(stim_t s);
    grid_result_t r;
    while (!in_calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {s.hh, s.hw, s.py, s.px, s.id};
    s_axis_tuser  <= s.op;
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_grid_op(s);
    if (s.has_exp) begin
      r.mask = s.exp_mask;
      r.clamp = s.exp_clamp;
    end
    pending.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [CFG_W-1:0] val);
    s_axis_tvalid <= 0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_HALF_X) half_x = val;
    else if (idx == CFG_HALF_Y) half_y = val;
    else if (idx == CFG_CELL_SIZE) csize = val;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic stim_t mk(logic [1:0] op, logic [5:0] id, logic [23:0] px,
                               logic [23:0] py, logic [21:0] hw, logic [21:0] hh);
    stim_t s;
    s.op = op; s.id = id; s.px = px; s.py = py; s.hw = hw; s.hh = hh;
    s.has_exp = 0; s.exp_mask = '0; s.exp_clamp = 0;
    return s;
  endfunction

  function automatic stim_t mk_exp(stim_t s, logic [63:0] m, logic c);
    s.has_exp = 1; s.exp_mask = m; s.exp_clamp = c;
    return s;
  endfunction

  function automatic stim_t rand_item();
    stim_t s;
    int k;
    k = $urandom_range(99);
    s = mk(k < 45 ? OP_UPDATE : (k < 60 ? OP_REMOVE : (k < 97 ? OP_QUERY : 2'd3)),
           6'($urandom), 24'($urandom), 24'($urandom), 22'($urandom), 22'($urandom));
    if ($urandom_range(9) < 8) begin
      s.px = 24'($signed($urandom_range(0, 5000)) - 2600);
      s.py = 24'($signed($urandom_range(0, 5000)) - 2600);
      s.hw = 22'($urandom_range(0, 300));
      s.hh = 22'($urandom_range(0, 300));
    end
    return s;
  endfunction

  always @(negedge clk_i) begin
    if (cycles > 400) m_axis_tready <= out_calm ? 1'b1 : ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    grid_result_t e;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result mask=%h", m_axis_tdata);
        errors++;
      end else begin
        e = pending.pop_front();
        if (m_axis_tdata !== e.mask) begin
          $error("found_mask exp=%h act=%h", e.mask, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== e.clamp) begin
          $error("clamped exp=%b act=%b", e.clamp, m_axis_tuser);
          errors++;
        end
      end
    end
    if (cycles > 40000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  stim_t table_q [$];

  initial begin
    int drain;
    for (int i = 0; i < NUM_CELLS; i++) cells[i] = '0;
    for (int i = 0; i < MAX_ENTITIES; i++) begin
      ent_valid[i] = 0;
      ent_x0[i] = 0; ent_y0[i] = 0; ent_x1[i] = 0; ent_y1[i] = 0;
    end
    half_x = 2048; half_y = 2048; csize = 256;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;

    table_q.push_back(mk_exp(mk(OP_QUERY, 0, 0, 0, 0, 0), '0, 0));
    table_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0));
    table_q.push_back(mk(OP_UPDATE, 63, 24'h800000, 24'h7fffff, 22'h3fffff, 0));
    table_q.push_back(mk(OP_UPDATE, 5, 24'h7fffff, 24'h800000, 0, 22'h3fffff));
    table_q.push_back(mk(OP_QUERY, 0, 24'hfff800, 24'hfff800, 22'h3fffff, 22'h3fffff));
    table_q.push_back(mk(OP_REMOVE, 63, 0, 0, 0, 0));
    table_q.push_back(mk_exp(mk(OP_REMOVE, 17, 0, 0, 0, 0), '0, 0));
    table_q.push_back(mk_exp(mk(2'd3, 9, 24'h800000, 24'h800000, 0, 0), '0, 0));
    table_q.push_back(mk(OP_QUERY, 0, 24'h800000, 24'h800000, 0, 0));
    table_q.push_back(mk(OP_QUERY, 0, 24'h7fffff, 24'h7fffff, 0, 0));
    table_q.push_back(mk(OP_UPDATE, 42, 24'hffff00, 24'h000100, 22'h80, 22'h180));
    table_q.push_back(mk(OP_QUERY, 0, 24'hffff00, 24'h000200, 0, 0));
    foreach (table_q[i]) send_item(table_q[i]);

    write_cfg(CFG_CELL_SIZE, 0);
    send_item(mk(OP_UPDATE, 3, 24'h000010, 24'h000010, 4, 4));
    send_item(mk(OP_QUERY, 0, 24'hfff800, 24'hfff800, 22'h3fffff, 22'h3fffff));
    write_cfg(CFG_CELL_SIZE, 23'h7fffff);
    write_cfg(CFG_HALF_X, 0);
    write_cfg(CFG_HALF_Y, 23'h7fffff);
    send_item(mk(OP_UPDATE, 7, 24'h7fffff, 24'h800000, 22'h3fffff, 22'h3fffff));
    send_item(mk(OP_QUERY, 0, 0, 0, 0, 0));
    write_cfg(2'd3, 23'h1234);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_HALF_X, 2048); write_cfg(CFG_HALF_Y, 2048);
                 write_cfg(CFG_CELL_SIZE, 256); end
        1: begin write_cfg(CFG_CELL_SIZE, 23'($urandom_range(1, 100))); end
        2: begin write_cfg(CFG_HALF_X, 23'($urandom_range(0, 4096)));
                 write_cfg(CFG_CELL_SIZE, 23'($urandom_range(100, 600))); end
        3: begin write_cfg(CFG_HALF_Y, 23'($urandom)); write_cfg(CFG_CELL_SIZE, 1); end
        default: begin write_cfg(CFG_HALF_X, 2048); write_cfg(CFG_HALF_Y, 2048);
                 write_cfg(CFG_CELL_SIZE, 160); end
      endcase
      in_calm = (ph == 2);
      out_calm = (ph == 2);
      for (int n = 0; n < 300; n++) send_item(rand_item());
    end

    s_axis_tvalid <= 0;
    drain = 0;
    while (pending.size() != 0 && drain < 200000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
